// ===== design/diff_drive_pwm_mixer_watchdog_top_defines.svh =====
// ----------------------------------------------------------------------------
// Differential drive mixer: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DIFF_DRIVE_PWM_MIXER_WATCHDOG_TOP_DEFINES_SVH
`define DIFF_DRIVE_PWM_MIXER_WATCHDOG_TOP_DEFINES_SVH

// same-cycle implication
`define DDPM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DDPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ddpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Differential drive mixer package
// Codes, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddpm_pkg;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned VEL_W       = 16;
   localparam int unsigned PWM_W       = 9;

   localparam logic [1:0] REQ_VELOCITY = 2'd0;
   localparam logic [1:0] REQ_DIRECT   = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;

   localparam logic ACT_MOTOR = 1'b0;
   localparam logic ACT_BRAKE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_LINEAR_DEADBAND = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_WHEEL_BASE = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SPEED_GAIN      = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PWM_LIMIT       = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PWM_FLOOR       = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_LEFT_TRIM       = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_RIGHT_TRIM      = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_TIMEOUT_US      = 4'd7;

   localparam logic [9:0]  RST_LINEAR_DEADBAND = 10'd5;
   localparam logic [15:0] RST_HALF_WHEEL_BASE = 16'd5243;
   localparam logic [19:0] RST_SPEED_GAIN      = 20'd20972;
   localparam logic [7:0]  RST_PWM_LIMIT       = 8'd80;
   localparam logic [7:0]  RST_PWM_FLOOR       = 8'd0;
   localparam logic [9:0]  RST_TRIM            = 10'd256;
   localparam logic [23:0] RST_TIMEOUT_US      = 24'd250000;

   localparam logic [9:0] TRIM_MAX = 10'd512;

   localparam int unsigned ANGULAR_DEADBAND_DEF = 10;
   localparam bit          BRAKE_ON_STOP_DEF    = 1'b1;

endpackage

// ===== design/ddpm_ifs.sv =====
// ----------------------------------------------------------------------------
// Differential drive mixer channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ddpm_req_if import ddpm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              req_type;
   logic signed [VEL_W-1:0] linear_vel;
   logic signed [VEL_W-1:0] angular_vel;
   logic signed [VEL_W-1:0] left_duty_cmd;
   logic signed [VEL_W-1:0] right_duty_cmd;
   logic [31:0]             time_us;

   modport source (output valid, req_type, linear_vel, angular_vel, left_duty_cmd,
                   right_duty_cmd, time_us, input ready);
   modport sink (input valid, req_type, linear_vel, angular_vel, left_duty_cmd,
                 right_duty_cmd, time_us, output ready);
endinterface

interface ddpm_rsp_if import ddpm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    action;
   logic signed [PWM_W-1:0] left_duty;
   logic signed [PWM_W-1:0] right_duty;
   logic                    stale;

   modport source (output valid, action, left_duty, right_duty, stale, input ready);
   modport sink (input valid, action, left_duty, right_duty, stale, output ready);
endinterface

interface ddpm_csr_if import ddpm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== design/diff_drive_pwm_mixer_watchdog_top.sv =====
// ---- Differential drive PWM mixer with command watchdog --------------------
// Velocity word: states S_OFF, S_MIX, S_GAIN_L, S_GAIN_R, S_TRIM_L, S_TRIM_R, S_STORE;
// one shared 32x20 multiplier used five times in turn; direct PWM word: set in idle;
// send tick: S_EMIT loads the response once the output is free, then back to idle.
// Synchronous active-high reset: registers to defaults, targets and time zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_pwm_mixer_watchdog_top import ddpm_pkg::*; #(
   parameter int unsigned ANGULAR_DEADBAND = ANGULAR_DEADBAND_DEF,
   parameter bit          BRAKE_ON_STOP    = BRAKE_ON_STOP_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ddpm_req_if.sink   req_port,
   ddpm_rsp_if.source rsp_port,
   ddpm_csr_if.sink   csr_port
);

   localparam logic [15:0] ANG_DB = 16'(ANGULAR_DEADBAND);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_OFF    = 4'd1;
   localparam logic [3:0] S_MIX    = 4'd2;
   localparam logic [3:0] S_GAIN_L = 4'd3;
   localparam logic [3:0] S_GAIN_R = 4'd4;
   localparam logic [3:0] S_TRIM_L = 4'd5;
   localparam logic [3:0] S_TRIM_R = 4'd6;
   localparam logic [3:0] S_STORE  = 4'd7;
   localparam logic [3:0] S_EMIT   = 4'd8;

   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
   } wheel_type;

   function automatic wheel_type sm_add(input logic sa, input logic [31:0] ma,
                                        input logic sc, input logic [31:0] mc);
      wheel_type w;
      if (sa == sc) begin
         w.neg = sa;
         w.mag = ma + mc;
      end else if (ma >= mc) begin
         w.neg = sa;
         w.mag = ma - mc;
      end else begin
         w.neg = sc;
         w.mag = mc - ma;
      end
      return w;
   endfunction

   function automatic logic [7:0] clamp_floor(input logic [20:0] m, input logic [7:0] lim,
                                              input logic [7:0] fl);
      logic [7:0] c;
      c = (m > {13'd0, lim}) ? lim : m[7:0];
      if (c != 8'd0 && c < fl) c = fl;
      return c;
   endfunction

   function automatic logic signed [8:0] apply_sign(input logic neg, input logic [7:0] m);
      logic signed [8:0] v;
      v = $signed({1'b0, m});
      return neg ? -v : v;
   endfunction

   function automatic logic signed [8:0] clamp_direct(input logic signed [15:0] v,
                                                      input logic [7:0] lim);
      logic signed [15:0] hi;
      logic signed [15:0] lo;
      hi = $signed({8'd0, lim});
      lo = -hi;
      if (v > hi) return hi[8:0];
      else if (v < lo) return lo[8:0];
      else return v[8:0];
   endfunction

   function automatic logic [15:0] abs16(input logic signed [15:0] v);
      return v[15] ? (~v + 16'd1) : v;
   endfunction

   // registers
   logic [9:0]  ldb_ff;
   logic [15:0] hwb_ff;
   logic [19:0] gain_ff;
   logic [7:0]  lim_ff;
   logic [7:0]  floor_ff;
   logic [9:0]  ltrim_ff;
   logic [9:0]  rtrim_ff;
   logic [23:0] tmo_ff;

   logic [3:0]        state_ff, state_in;
   logic              lin_neg_ff, lin_neg_in;
   logic [15:0]       lin_mag_ff, lin_mag_in;
   logic              ang_neg_ff, ang_neg_in;
   logic [15:0]       ang_mag_ff, ang_mag_in;
   logic [31:0]       time_ff, time_in;
   wheel_type         wl_ff, wl_in;
   wheel_type         wr_ff, wr_in;
   logic              zl_ff, zl_in;
   logic              zr_ff, zr_in;
   logic [7:0]        pl_mag_ff, pl_mag_in;
   logic [7:0]        pr_mag_ff, pr_mag_in;
   logic [51:0]       prod_ff, prod_in;
   logic              expired_ff, expired_in;
   logic signed [8:0] target_left_ff, target_left_in;
   logic signed [8:0] target_right_ff, target_right_in;
   logic signed [8:0] sent_left_ff, sent_left_in;
   logic signed [8:0] sent_right_ff, sent_right_in;
   logic [31:0]       cmd_time_ff, cmd_time_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_action_ff, rsp_action_in;
   logic signed [8:0] rsp_left_ff, rsp_left_in;
   logic signed [8:0] rsp_right_ff, rsp_right_in;
   logic              rsp_stale_ff, rsp_stale_in;

   // shared multiplier operands
   logic [31:0] mul_a;
   logic [19:0] mul_b;

   logic [7:0]  floor_eff;
   logic [9:0]  ltrim_eff;
   logic [9:0]  rtrim_eff;
   logic [20:0] g_round;
   logic [20:0] t_round;
   logic [31:0] base_mag;
   logic [15:0] lin_abs;
   logic [15:0] ang_abs;
   logic [31:0] age;
   logic signed [8:0] pick_l;
   logic signed [8:0] pick_r;
   logic        stop;
   logic        accept;

   assign accept    = req_port.valid && req_port.ready;
   assign floor_eff = (floor_ff < lim_ff) ? floor_ff : lim_ff;
   assign ltrim_eff = (ltrim_ff > TRIM_MAX) ? TRIM_MAX : ltrim_ff;
   assign rtrim_eff = (rtrim_ff > TRIM_MAX) ? TRIM_MAX : rtrim_ff;
   assign g_round   = {1'b0, prod_ff[51:32]} + 21'(prod_ff[31]);
   assign t_round   = {12'd0, prod_ff[16:8]} + 21'(prod_ff[7]);
   assign base_mag  = {lin_mag_ff, 16'd0};
   assign lin_abs   = abs16(req_port.linear_vel);
   assign ang_abs   = abs16(req_port.angular_vel);
   assign age       = req_port.time_us - cmd_time_ff;
   assign pick_l    = expired_ff ? 9'sd0 : target_left_ff;
   assign pick_r    = expired_ff ? 9'sd0 : target_right_ff;
   assign stop      = BRAKE_ON_STOP && pick_l == 9'sd0 && pick_r == 9'sd0;

   always_comb begin
      mul_a = 32'd0;
      mul_b = 20'd0;
      case (state_ff)
         S_OFF: begin
            mul_a = {16'd0, ang_mag_ff};
            mul_b = {4'd0, hwb_ff};
         end
         S_GAIN_L: begin
            mul_a = wl_ff.mag;
            mul_b = gain_ff;
         end
         S_GAIN_R: begin
            mul_a = wr_ff.mag;
            mul_b = gain_ff;
         end
         S_TRIM_L: begin
            mul_a = {24'd0, pl_mag_ff};
            mul_b = {10'd0, ltrim_eff};
         end
         S_TRIM_R: begin
            mul_a = {24'd0, pr_mag_ff};
            mul_b = {10'd0, rtrim_eff};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 20'd0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in         = state_ff;
      lin_neg_in       = lin_neg_ff;
      lin_mag_in       = lin_mag_ff;
      ang_neg_in       = ang_neg_ff;
      ang_mag_in       = ang_mag_ff;
      time_in          = time_ff;
      wl_in            = wl_ff;
      wr_in            = wr_ff;
      zl_in            = zl_ff;
      zr_in            = zr_ff;
      pl_mag_in        = pl_mag_ff;
      pr_mag_in        = pr_mag_ff;
      expired_in       = expired_ff;
      target_left_in   = target_left_ff;
      target_right_in  = target_right_ff;
      sent_left_in     = sent_left_ff;
      sent_right_in    = sent_right_ff;
      cmd_time_in      = cmd_time_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_port.ready;
      rsp_action_in    = rsp_action_ff;
      rsp_left_in      = rsp_left_ff;
      rsp_right_in     = rsp_right_ff;
      rsp_stale_in     = rsp_stale_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_port.req_type)
                  REQ_VELOCITY: begin
                     lin_neg_in = req_port.linear_vel[15];
                     lin_mag_in = (lin_abs < {6'd0, ldb_ff}) ? 16'd0 : lin_abs;
                     ang_neg_in = req_port.angular_vel[15];
                     ang_mag_in = (ang_abs < ANG_DB) ? 16'd0 : ang_abs;
                     time_in    = req_port.time_us;
                     state_in   = S_OFF;
                  end
                  REQ_DIRECT: begin
                     target_left_in  = clamp_direct(req_port.left_duty_cmd, lim_ff);
                     target_right_in = clamp_direct(req_port.right_duty_cmd, lim_ff);
                     cmd_time_in     = req_port.time_us;
                  end
                  REQ_TICK: begin
                     expired_in = age > {8'd0, tmo_ff};
                     state_in   = S_EMIT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_OFF: state_in = S_MIX;
         S_MIX: begin
            // left = base - offset, right = base + offset
            wl_in    = sm_add(lin_neg_ff, base_mag, !ang_neg_ff, prod_ff[31:0]);
            wr_in    = sm_add(lin_neg_ff, base_mag, ang_neg_ff, prod_ff[31:0]);
            state_in = S_GAIN_L;
         end
         S_GAIN_L: begin
            zl_in    = (wl_ff.mag < {6'd0, ldb_ff, 16'd0}) || gain_ff == 20'd0;
            zr_in    = (wr_ff.mag < {6'd0, ldb_ff, 16'd0}) || gain_ff == 20'd0;
            state_in = S_GAIN_R;
         end
         S_GAIN_R: begin
            pl_mag_in = zl_ff ? 8'd0 : clamp_floor(g_round, lim_ff, floor_eff);
            state_in  = S_TRIM_L;
         end
         S_TRIM_L: begin
            pr_mag_in = zr_ff ? 8'd0 : clamp_floor(g_round, lim_ff, floor_eff);
            state_in  = S_TRIM_R;
         end
         S_TRIM_R: begin
            target_left_in = apply_sign(wl_ff.neg, clamp_floor(t_round, lim_ff, floor_eff));
            state_in       = S_STORE;
         end
         S_STORE: begin
            target_right_in = apply_sign(wr_ff.neg, clamp_floor(t_round, lim_ff, floor_eff));
            cmd_time_in     = time_ff;
            state_in        = S_IDLE;
         end
         S_EMIT: begin
            if (stop && sent_left_ff == 9'sd0 && sent_right_ff == 9'sd0) begin
               state_in = S_IDLE;
            end else if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in     = 1'b1;
               rsp_action_in    = stop ? ACT_BRAKE : ACT_MOTOR;
               rsp_left_in      = pick_l;
               rsp_right_in     = pick_r;
               rsp_stale_in     = expired_ff;
               sent_left_in     = pick_l;
               sent_right_in    = pick_r;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         target_left_ff  <= 9'sd0;
         target_right_ff <= 9'sd0;
         sent_left_ff    <= 9'sd0;
         sent_right_ff   <= 9'sd0;
         cmd_time_ff     <= 32'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         target_left_ff  <= target_left_in;
         target_right_ff <= target_right_in;
         sent_left_ff    <= sent_left_in;
         sent_right_ff   <= sent_right_in;
         cmd_time_ff     <= cmd_time_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lin_neg_ff       <= lin_neg_in;
      lin_mag_ff       <= lin_mag_in;
      ang_neg_ff       <= ang_neg_in;
      ang_mag_ff       <= ang_mag_in;
      time_ff          <= time_in;
      wl_ff            <= wl_in;
      wr_ff            <= wr_in;
      zl_ff            <= zl_in;
      zr_ff            <= zr_in;
      pl_mag_ff        <= pl_mag_in;
      pr_mag_ff        <= pr_mag_in;
      prod_ff          <= prod_in;
      expired_ff       <= expired_in;
      rsp_action_ff    <= rsp_action_in;
      rsp_left_ff      <= rsp_left_in;
      rsp_right_ff     <= rsp_right_in;
      rsp_stale_ff     <= rsp_stale_in;
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         ldb_ff   <= RST_LINEAR_DEADBAND;
         hwb_ff   <= RST_HALF_WHEEL_BASE;
         gain_ff  <= RST_SPEED_GAIN;
         lim_ff   <= RST_PWM_LIMIT;
         floor_ff <= RST_PWM_FLOOR;
         ltrim_ff <= RST_TRIM;
         rtrim_ff <= RST_TRIM;
         tmo_ff   <= RST_TIMEOUT_US;
      end else if (csr_port.valid && csr_port.ready) begin
         case (csr_port.index)
            REG_LINEAR_DEADBAND: ldb_ff   <= csr_port.wdata[9:0];
            REG_HALF_WHEEL_BASE: hwb_ff   <= csr_port.wdata[15:0];
            REG_SPEED_GAIN:      gain_ff  <= csr_port.wdata[19:0];
            REG_PWM_LIMIT:       lim_ff   <= csr_port.wdata[7:0];
            REG_PWM_FLOOR:       floor_ff <= csr_port.wdata[7:0];
            REG_LEFT_TRIM:       ltrim_ff <= csr_port.wdata[9:0];
            REG_RIGHT_TRIM:      rtrim_ff <= csr_port.wdata[9:0];
            REG_TIMEOUT_US:      tmo_ff   <= csr_port.wdata[23:0];
            default: ;
         endcase
      end
   end

   assign req_port.ready      = (state_ff == S_IDLE);
   assign csr_port.ready      = 1'b1;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.action     = rsp_action_ff;
   assign rsp_port.left_duty  = rsp_left_ff;
   assign rsp_port.right_duty = rsp_right_ff;
   assign rsp_port.stale      = rsp_stale_ff;

endmodule

// ===== design/ddpm_checker.sv =====
// ----------------------------------------------------------------------------
// Differential drive mixer port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "diff_drive_pwm_mixer_watchdog_top_defines.svh"

module ddpm_checker import ddpm_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic [1:0]              req_type,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic                    rsp_action,
   input logic signed [PWM_W-1:0] rsp_left_duty,
   input logic signed [PWM_W-1:0] rsp_right_duty,
   input logic                    rsp_stale
);

   `DDPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_left_duty) && $stable(rsp_right_duty) && $stable(rsp_action),
      "response word changed while stalled")

   `DDPM_ASSERT_SAME(a_brake_zero, clock, reset, rsp_valid && rsp_action == ACT_BRAKE,
      rsp_left_duty == 9'sd0 && rsp_right_duty == 9'sd0, "brake word with non-zero pwm")

   `DDPM_ASSERT_SAME(a_timeout_zero, clock, reset, rsp_valid && rsp_stale,
      rsp_left_duty == 9'sd0 && rsp_right_duty == 9'sd0, "expired word with non-zero pwm")

   `DDPM_ASSERT_NEXT(a_vel_busy, clock, reset,
      req_valid && req_ready && req_type == REQ_VELOCITY, !req_ready,
      "ready right after velocity word")

endmodule

bind diff_drive_pwm_mixer_watchdog_top ddpm_checker u_ddpm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .req_type       (req_port.req_type),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_action     (rsp_port.action),
   .rsp_left_duty  (rsp_port.left_duty),
   .rsp_right_duty (rsp_port.right_duty),
   .rsp_stale      (rsp_port.stale)
);

// ===== verif/diff_drive_pwm_mixer_watchdog_top_tb.sv =====
// ----------------------------------------------------------------------------
// Differential drive mixer testbench
// Drives velocity, direct PWM and send tick words with random gaps on both
// channels. An in-bench predictor tracks targets, sent values and command age.
// It checks every response word in order. Registers are reloaded between
// phases, and the phases include the zero and full-scale settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diff_drive_pwm_mixer_watchdog_top_tb;
   import ddpm_pkg::*;

   localparam int          CLK_PERIOD    = 20;
   localparam int          SETTLE_CYCLES = 16;
   localparam int          STALL_LIMIT   = 2000;
   localparam int          PHASE_WORDS   = 235;
   localparam logic [1:0]  REQ_UNUSED    = 2'd3;

   typedef struct packed {
      logic [1:0]              kind;
      logic signed [VEL_W-1:0] lin_vel;
      logic signed [VEL_W-1:0] ang_vel;
      logic signed [VEL_W-1:0] left_cmd;
      logic signed [VEL_W-1:0] right_cmd;
      logic [31:0]             stamp;
   } mixer_word_type;

   typedef struct packed {
      logic                    action;
      logic signed [PWM_W-1:0] left_duty;
      logic signed [PWM_W-1:0] right_duty;
      logic                    stale;
   } wheel_cmd_type;

   typedef struct {
      int unsigned lin_db;
      int unsigned half_base;
      int unsigned gain;
      int unsigned pwm_max;
      int unsigned pwm_min;
      int unsigned trim_l;
      int unsigned trim_r;
      int unsigned timeout;
   } mixer_cfg_type;

   class mixer_scoreboard;
      longint        lin_db, half_base, gain, pwm_max, pwm_min, trim_l, trim_r, timeout;
      longint        tgt_l, tgt_r, sent_l, sent_r;
      logic [31:0]   cmd_stamp;
      wheel_cmd_type expected_cmds[$];
      int unsigned   mismatches;

      function new();
         lin_db     = RST_LINEAR_DEADBAND;
         half_base  = RST_HALF_WHEEL_BASE;
         gain       = RST_SPEED_GAIN;
         pwm_max    = RST_PWM_LIMIT;
         pwm_min    = RST_PWM_FLOOR;
         trim_l     = RST_TRIM;
         trim_r     = RST_TRIM;
         timeout    = RST_TIMEOUT_US;
         tgt_l      = 0;
         tgt_r      = 0;
         sent_l     = 0;
         sent_r     = 0;
         cmd_stamp  = '0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_LINEAR_DEADBAND: lin_db    = longint'(data[9:0]);
            REG_HALF_WHEEL_BASE: half_base = longint'(data[15:0]);
            REG_SPEED_GAIN:      gain      = longint'(data[19:0]);
            REG_PWM_LIMIT:       pwm_max   = longint'(data[7:0]);
            REG_PWM_FLOOR:       pwm_min   = longint'(data[7:0]);
            REG_LEFT_TRIM:       trim_l    = longint'(data[9:0]);
            REG_RIGHT_TRIM:      trim_r    = longint'(data[9:0]);
            REG_TIMEOUT_US:      timeout   = longint'(data[23:0]);
            default: ;
         endcase
      endfunction

      function longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // divide by 2^sh, rounding half away from zero
      function longint round_half_away(longint num, int unsigned sh);
         longint r;
         r = (mag(num) + (longint'(1) << (sh - 1))) >> sh;
         return (num < 0) ? -r : r;
      endfunction

      function longint clamp_pwm(longint v);
         if (v > pwm_max) return pwm_max;
         if (v < -pwm_max) return -pwm_max;
         return v;
      endfunction

      function longint clamp_floor(longint v);
         longint fl;
         fl = (pwm_min < pwm_max) ? pwm_min : pwm_max;
         v = clamp_pwm(v);
         if (v != 0 && mag(v) < fl) v = (v > 0) ? fl : -fl;
         return v;
      endfunction

      // w is the wheel speed in Q16 mm/s
      function longint wheel_pwm(longint w, longint trim);
         longint p, t;
         t = (trim > TRIM_MAX) ? longint'(TRIM_MAX) : trim;
         if (mag(w) < (lin_db << 16) || gain == 0) p = 0;
         else p = round_half_away(w * gain, 32);
         p = clamp_floor(p);
         p = round_half_away(p * t, 8);
         return clamp_floor(p);
      endfunction

      function void note_request(mixer_word_type w);
         longint        lin, ang, base, off, l, r;
         logic [31:0]   age;
         bit            expired;
         wheel_cmd_type c;
         case (w.kind)
            REQ_VELOCITY: begin
               lin = longint'($signed(w.lin_vel));
               ang = longint'($signed(w.ang_vel));
               if (mag(lin) < lin_db) lin = 0;
               if (mag(ang) < ANGULAR_DEADBAND_DEF) ang = 0;
               base      = lin * 65536;
               off       = ang * half_base;
               tgt_l     = wheel_pwm(base - off, trim_l);
               tgt_r     = wheel_pwm(base + off, trim_r);
               cmd_stamp = w.stamp;
            end
            REQ_DIRECT: begin
               tgt_l     = clamp_pwm(longint'($signed(w.left_cmd)));
               tgt_r     = clamp_pwm(longint'($signed(w.right_cmd)));
               cmd_stamp = w.stamp;
            end
            REQ_TICK: begin
               age     = w.stamp - cmd_stamp;
               expired = longint'(age) > timeout;
               l       = expired ? 0 : tgt_l;
               r       = expired ? 0 : tgt_r;
               if (l == 0 && r == 0 && BRAKE_ON_STOP_DEF) begin
                  if (sent_l == 0 && sent_r == 0) return;
                  c.action = ACT_BRAKE;
               end else begin
                  c.action = ACT_MOTOR;
               end
               sent_l       = l;
               sent_r       = r;
               c.left_duty  = l[PWM_W-1:0];
               c.right_duty = r[PWM_W-1:0];
               c.stale      = expired;
               expected_cmds.push_back(c);
            end
            default: ;
         endcase
      endfunction

      function void log_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      function void check_result(wheel_cmd_type got);
         wheel_cmd_type want;
         if (expected_cmds.size() == 0) begin
            log_mismatch($sformatf("unexpected word act %0b L %0d R %0d to %0b",
                                   got.action, $signed(got.left_duty),
                                   $signed(got.right_duty), got.stale));
            return;
         end
         want = expected_cmds.pop_front();
         if (got.action !== want.action || got.left_duty !== want.left_duty ||
             got.right_duty !== want.right_duty || got.stale !== want.stale)
            log_mismatch($sformatf(
               "exp act %0b L %0d R %0d to %0b, got act %0b L %0d R %0d to %0b",
               want.action, $signed(want.left_duty), $signed(want.right_duty),
               want.stale, got.action, $signed(got.left_duty),
               $signed(got.right_duty), got.stale));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddpm_req_if req_bus ();
   ddpm_rsp_if rsp_bus ();
   ddpm_csr_if csr_bus ();

   diff_drive_pwm_mixer_watchdog_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   mixer_scoreboard sb;
   logic [31:0]     now_us   = '0;
   logic [31:0]     cmd_us   = '0;
   bit              burst_req = 1'b0;
   bit              burst_rsp = 1'b0;
   int              idle_cycles = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap(bit burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic signed [VEL_W-1:0] signed_mag(int unsigned m);
      int v;
      v = $urandom_range(1, 0) ? -int'(m) : int'(m);
      return v[VEL_W-1:0];
   endfunction

   function automatic logic signed [VEL_W-1:0] pick_speed(int unsigned db);
      case ($urandom_range(5, 0))
         0:       return 16'($urandom);
         1:       return signed_mag($urandom_range(db + 2, 0));
         2:       return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
         3, 4:    return signed_mag($urandom_range(3000, 0));
         default: return signed_mag($urandom_range(300, 0));
      endcase
   endfunction

   function automatic logic signed [VEL_W-1:0] pick_pwm();
      case ($urandom_range(3, 0))
         0:       return 16'($urandom);
         1:       return signed_mag($urandom_range(300, 0));
         2:       return $urandom_range(1, 0) ? 16'sh7FFF : 16'sh8000;
         default: return signed_mag($urandom_range(int'(sb.pwm_max) + 2, 0));
      endcase
   endfunction

   // commands followed by ticks aged around the timeout, with some noise
   function automatic mixer_word_type make_word();
      mixer_word_type w;
      int unsigned    sel, tmo;
      logic [31:0]    age;
      tmo         = int'(sb.timeout);
      w.lin_vel   = 16'($urandom);
      w.ang_vel   = 16'($urandom);
      w.left_cmd  = 16'($urandom);
      w.right_cmd = 16'($urandom);
      w.stamp     = $urandom;
      sel         = $urandom_range(99, 0);
      if (sel < 3) begin
         w.kind = REQ_UNUSED;
         return w;
      end
      if (sel < 55) begin
         if (sel < 40) begin
            w.kind    = REQ_VELOCITY;
            w.lin_vel = pick_speed(int'(sb.lin_db));
            w.ang_vel = pick_speed(ANGULAR_DEADBAND_DEF);
         end else begin
            w.kind      = REQ_DIRECT;
            w.left_cmd  = pick_pwm();
            w.right_cmd = pick_pwm();
         end
         case ($urandom_range(19, 0))
            0:       now_us = $urandom;
            1:       now_us = 32'hFFFF_F000 + $urandom_range(4095, 0);
            default: now_us = now_us + $urandom_range(2000, 0);
         endcase
         w.stamp = now_us;
         cmd_us  = now_us;
         return w;
      end
      w.kind = REQ_TICK;
      case ($urandom_range(9, 0))
         5:       age = tmo;
         6:       age = tmo + 1;
         7:       age = tmo + $urandom_range(1000, 2);
         8:       age = $urandom;
         default: age = $urandom_range(tmo, 0);
      endcase
      w.stamp = cmd_us + age;
      now_us  = w.stamp;
      return w;
   endfunction

   function automatic mixer_cfg_type rand_cfg();
      mixer_cfg_type c;
      c.lin_db    = $urandom_range(60, 0);
      c.half_base = $urandom_range(65535, 0);
      c.gain      = ($urandom_range(3, 0) == 0) ? $urandom_range(1048575, 0)
                                                 : $urandom_range(120000, 0);
      c.pwm_max   = $urandom_range(255, 0);
      c.pwm_min   = $urandom_range(1, 0) ? $urandom_range(255, 0)
                                         : $urandom_range(c.pwm_max / 2, 0);
      c.trim_l    = ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0)
                                                 : $urandom_range(600, 0);
      c.trim_r    = ($urandom_range(3, 0) == 0) ? $urandom_range(1023, 0)
                                                 : $urandom_range(600, 0);
      c.timeout   = ($urandom_range(2, 0) == 0) ? $urandom_range(16777215, 0)
                                                 : $urandom_range(300000, 0);
      return c;
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, data);
   endtask

   task automatic load_config(mixer_cfg_type c);
      write_csr(REG_LINEAR_DEADBAND, c.lin_db);
      write_csr(REG_HALF_WHEEL_BASE, c.half_base);
      write_csr(REG_SPEED_GAIN, c.gain);
      write_csr(REG_PWM_LIMIT, c.pwm_max);
      write_csr(REG_PWM_FLOOR, c.pwm_min);
      write_csr(REG_LEFT_TRIM, c.trim_l);
      write_csr(REG_RIGHT_TRIM, c.trim_r);
      write_csr(REG_TIMEOUT_US, c.timeout);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_word(mixer_word_type w);
      req_bus.valid          <= 1'b1;
      req_bus.req_type       <= w.kind;
      req_bus.linear_vel     <= w.lin_vel;
      req_bus.angular_vel    <= w.ang_vel;
      req_bus.left_duty_cmd  <= w.left_cmd;
      req_bus.right_duty_cmd <= w.right_cmd;
      req_bus.time_us        <= w.stamp;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(w);
   endtask

   task automatic post_gap();
      int g;
      g = pick_gap(burst_req);
      if (g > 0) begin
         req_bus.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // hold off until every response is in, then let a velocity word finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.expected_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic issue(logic [1:0] kind, int lin, int ang, int lp, int rp,
                        logic [31:0] stamp);
      mixer_word_type w;
      w.kind      = kind;
      w.lin_vel   = lin[VEL_W-1:0];
      w.ang_vel   = ang[VEL_W-1:0];
      w.left_cmd  = lp[VEL_W-1:0];
      w.right_cmd = rp[VEL_W-1:0];
      w.stamp     = stamp;
      now_us      = stamp;
      if (kind == REQ_VELOCITY || kind == REQ_DIRECT) cmd_us = stamp;
      send_word(w);
      post_gap();
   endtask

   task automatic run_directed();
      issue(REQ_TICK,     0, 0, 0, 0, 32'd0);           // tick before any command
      issue(REQ_VELOCITY, 1000, 0, 0, 0, 32'd100);      // saturates at the limit
      issue(REQ_TICK,     0, 0, 0, 0, 32'd200);
      issue(REQ_VELOCITY, 4, 9, 0, 0, 32'd300);         // both inside deadband
      issue(REQ_TICK,     0, 0, 0, 0, 32'd400);         // brake
      issue(REQ_TICK,     0, 0, 0, 0, 32'd500);         // already stopped
      issue(REQ_VELOCITY, 32767, -32768, 0, 0, 32'd600);
      issue(REQ_TICK,     0, 0, 0, 0, 32'd700);
      issue(REQ_VELOCITY, -32768, 32767, 0, 0, 32'd800);
      issue(REQ_TICK,     0, 0, 0, 0, 32'd900);
      issue(REQ_VELOCITY, 5, 10, 0, 0, 32'd1000);       // right on the deadbands
      issue(REQ_TICK,     0, 0, 0, 0, 32'd1100);
      issue(REQ_DIRECT,   0, 0, 32767, -32768, 32'd1200);
      issue(REQ_TICK,     0, 0, 0, 0, 32'd1300);
      issue(REQ_DIRECT,   0, 0, -32768, 32767, 32'd1400);
      issue(REQ_TICK,     0, 0, 0, 0, 32'd1500);
      issue(REQ_DIRECT,   0, 0, 3, -3, 32'd2000);       // small, no floor
      issue(REQ_TICK,     0, 0, 0, 0, 32'd252000);      // age equals timeout
      issue(REQ_TICK,     0, 0, 0, 0, 32'd252001);      // expired, brake
      issue(REQ_UNUSED,   -1, -1, -1, -1, 32'hFFFF_FFFF);
      issue(REQ_DIRECT,   0, 0, 7, 0, 32'hFFFF_FF00);
      issue(REQ_TICK,     0, 0, 0, 0, 32'h0000_0010);   // age across the wrap
      issue(REQ_VELOCITY, -1000, 300, 0, 0, 32'h0000_0020);
      issue(REQ_TICK,     0, 0, 0, 0, 32'h0000_0030);
      issue(REQ_TICK,     0, 0, 0, 0, 32'h0004_93F0);   // expired
   endtask

   task automatic run_random(int unsigned n);
      int unsigned    done;
      mixer_word_type w;
      done = 0;
      while (done < n) begin
         if (done % 100 == 0) burst_req = ($urandom_range(3, 0) == 0);
         w = make_word();
         send_word(w);
         if (w.kind != REQ_UNUSED) done++;
         if ($urandom_range(149, 0) == 0) settle();
         else post_gap();
      end
      burst_req = 1'b0;
   endtask

   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         burst_rsp = ($urandom_range(19, 0) == 0);
         rsp_bus.ready <= 1'b1;
         repeat (burst_rsp ? $urandom_range(300, 100) : $urandom_range(8, 1))
            @(posedge clock);
         stall = pick_gap(1'b0);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result('{rsp_bus.action, rsp_bus.left_duty, rsp_bus.right_duty,
                           rsp_bus.stale});
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      mixer_cfg_type cfg;
      sb = new();
      req_bus.valid          <= 1'b0;
      req_bus.req_type       <= REQ_VELOCITY;
      req_bus.linear_vel     <= '0;
      req_bus.angular_vel    <= '0;
      req_bus.left_duty_cmd  <= '0;
      req_bus.right_duty_cmd <= '0;
      req_bus.time_us        <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.index          <= REG_LINEAR_DEADBAND;
      csr_bus.wdata          <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(PHASE_WORDS);
      settle();

      cfg = '{0, 0, 0, 0, 0, 0, 0, 0};
      load_config(cfg);
      run_random(PHASE_WORDS);
      settle();

      cfg = '{1023, 65535, 1048575, 255, 255, 1023, 1023, 16777215};
      load_config(cfg);
      run_random(PHASE_WORDS);
      settle();

      // floor above limit, trims past 2.0 and below 1.0
      cfg = '{20, 30000, 40000, 40, 200, 700, 100, 5000};
      load_config(cfg);
      run_random(PHASE_WORDS);
      settle();

      repeat (3) begin
         load_config(rand_cfg());
         run_random(PHASE_WORDS);
         settle();
      end

      if (sb.mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
